// ----- rtl/insertion_sort_engine_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Insertion sort engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORT_ENGINE_UNIT_DEFINES_SVH
`define INSERTION_SORT_ENGINE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISORT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISORT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/isort_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort engine package
// Element type codes, key functions and shared types.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int DATA_W           = 32;
    localparam int TYPE_W           = 3;

    localparam logic [TYPE_W-1:0] ETYPE_S8  = 3'd0;
    localparam logic [TYPE_W-1:0] ETYPE_U8  = 3'd1;
    localparam logic [TYPE_W-1:0] ETYPE_S16 = 3'd2;
    localparam logic [TYPE_W-1:0] ETYPE_U16 = 3'd3;
    localparam logic [TYPE_W-1:0] ETYPE_S32 = 3'd4;
    localparam logic [TYPE_W-1:0] ETYPE_U32 = 3'd5;
    localparam logic [TYPE_W-1:0] ETYPE_RESET = ETYPE_U8;

    // One result item headed for the output register.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } isort_out_t;

    function automatic logic [DATA_W-1:0] type_mask(input logic [TYPE_W-1:0] etype);
        logic [DATA_W-1:0] m;
        unique case (etype)
            ETYPE_S8, ETYPE_U8:   m = 32'h0000_00FF;
            ETYPE_S16, ETYPE_U16: m = 32'h0000_FFFF;
            default:              m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Sign bit of the element width for signed types, zero otherwise.
    function automatic logic [DATA_W-1:0] type_flip(input logic [TYPE_W-1:0] etype);
        logic [DATA_W-1:0] f;
        unique case (etype)
            ETYPE_S8:  f = 32'h0000_0080;
            ETYPE_S16: f = 32'h0000_8000;
            ETYPE_S32: f = 32'h8000_0000;
            default:   f = '0;
        endcase
        return f;
    endfunction

    // Flipping the sign bit lets an unsigned compare order signed values.
    function automatic logic [DATA_W-1:0] key_of(input logic [DATA_W-1:0] v,
                                                 input logic [TYPE_W-1:0] etype);
        return (v & type_mask(etype)) ^ type_flip(etype);
    endfunction

endpackage

// ----- rtl/isort_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module isort_ram #(
    parameter int WIDTH = isort_pkg::DATA_W,
    parameter int DEPTH = isort_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/isort_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort output register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module isort_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  isort_pkg::isort_out_t load_item,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // sorted_value
    output logic                  m_tlast,
    output logic                  m_tuser    // overflow
);

    logic                  valid_reg;
    logic                  valid_next;
    isort_pkg::isort_out_t item_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.value;
    assign m_tlast  = item_reg.last;
    assign m_tuser  = item_reg.ovf;

endmodule

// ----- rtl/isort_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort sequencer
// Walks the sorted store downward to insert an item, then reads it out.
// ----------------------------------------------------------------------------
`include "insertion_sort_engine_unit_defines.svh"

module isort_core #(
    parameter int MAX_ELEMENTS = isort_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [isort_pkg::TYPE_W-1:0]    element_type,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,
    input  logic                            s_tlast,
    output logic                            ram_wr_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0] ram_wr_addr,
    output logic [31:0]                     ram_wr_data,
    output logic                            ram_rd_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0] ram_rd_addr,
    input  logic [31:0]                     ram_rd_data,
    input  logic                            out_free,
    output logic                            out_load,
    output isort_pkg::isort_out_t           out_item
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SHIFT   = 5'b00010,
        ST_PLACE   = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT_LD = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   key_reg, key_next;
    logic          last_reg, last_next;

    logic [31:0]   mask;
    logic [31:0]   in_val;
    logic [31:0]   rd_key;
    logic          full;
    logic          idx_is_last;

    assign mask        = isort_pkg::type_mask(element_type);
    assign in_val      = s_tdata & mask;
    assign rd_key      = isort_pkg::key_of(ram_rd_data, element_type);
    assign full        = (count_reg == CW'(MAX_ELEMENTS));
    assign idx_is_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        key_next    = key_reg;
        last_next   = last_reg;
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg;
        ram_wr_data = val_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;
        out_load    = 1'b0;
        out_item.value = ram_rd_data & mask;
        out_item.last  = idx_is_last;
        out_item.ovf   = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    val_next  = in_val;
                    key_next  = isort_pkg::key_of(s_tdata, element_type);
                    last_next = s_tlast;
                    idx_next  = '0;
                    if (full)
                    begin
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? ST_EMIT_RD : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = in_val;
                        count_next  = CW'(1);
                        state_next  = s_tlast ? ST_EMIT_RD : ST_IDLE;
                    end
                    else
                    begin
                        // Fetch the current top entry; the walk goes down from there.
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(count_reg - CW'(1));
                        pos_next    = AW'(count_reg);
                        state_next  = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                if (rd_key > key_reg)
                begin
                    // Move the larger entry up and fetch the one below it.
                    ram_wr_data = ram_rd_data;
                    pos_next    = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_reg - AW'(1) - AW'(1);
                    end
                end
                else
                begin
                    ram_wr_data = val_reg;
                    count_next  = count_reg + CW'(1);
                    state_next  = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = val_reg;
                count_next  = count_reg + CW'(1);
                state_next  = last_reg ? ST_EMIT_RD : ST_IDLE;
            end

            ST_EMIT_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg;
                state_next  = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                // Read data holds until the next read, so a stalled sink is harmless.
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (idx_is_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next    = idx_reg + AW'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        key_reg  <= key_next;
        last_reg <= last_next;
    end

    `ISORT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(MAX_ELEMENTS), "count above capacity")
    `ISORT_ASSERT_SAME(a_no_rw_clash, ram_rd_en && ram_wr_en, ram_rd_addr != ram_wr_addr,
                       "read and write hit the same entry")
    `ISORT_ASSERT_SAME(a_write_in_range, ram_wr_en, CW'(ram_wr_addr) <= count_reg,
                       "write beyond the filled part of the store")
    `ISORT_ASSERT_SAME(a_emit_nonempty, out_load, count_reg != '0, "result from an empty store")
    `ISORT_ASSERT_NEXT(a_run_closes, out_load && out_item.last, count_reg == '0 && !ovf_reg,
                       "run state not cleared after final result")

endmodule

// ----- rtl/insertion_sort_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort engine
// Sorts a run of elements in a RAM-based store and streams them out in order.
// ----------------------------------------------------------------------------
// Each input item is inserted into a sorted store held in one RAM. An
// insertion into an empty store is a single write; otherwise every stored
// entry larger than the new element moves up one place, one entry per
// cycle, as the store is a single RAM. An item that arrives with a full
// store is dropped and flags overflow on every result of its run. After an
// item with tlast, the store is read out in ascending order, one result
// per cycle after a read start while the sink is ready; no input is taken
// until the last result is in the output register. element_type selects
// signed or unsigned 8, 16 or 32 bit elements (codes 6 and 7 act as
// unsigned 32); results are zero-extended. Write it only while the block
// is idle.
module insertion_sort_engine_unit #(
    parameter int MAX_ELEMENTS = isort_pkg::MAX_ELEMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,  // element_type
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // element_value
    input  logic        s_tlast,      // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // sorted_value
    output logic        m_tlast,      // last_result
    output logic        m_tuser       // overflow
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    logic [isort_pkg::TYPE_W-1:0] element_type_reg;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [31:0]           ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [31:0]           ram_rd_data;
    logic                  out_free;
    logic                  out_load;
    isort_pkg::isort_out_t out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_type_reg <= isort_pkg::ETYPE_RESET;
        end
        else if (cfg_wr_en)
        begin
            element_type_reg <= cfg_wr_data;
        end
    end

    isort_ram #(
        .WIDTH (isort_pkg::DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    isort_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .element_type (element_type_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_item     (out_item)
    );

    isort_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_item (out_item),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- tb/insertion_sort_engine_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort engine testbench
// Streams runs of elements into the sorter under every element type and
// checks each sorted item against a behavioral model of the sorted store,
// with random source gaps and sink stalls, full-store and overflow runs.
// ----------------------------------------------------------------------------
module insertion_sort_engine_unit_tb;

    import isort_pkg::*;

    localparam int CAPACITY     = MAX_ELEMENTS_DEF;
    localparam int RANDOM_ITEMS = 220;
    localparam int CYCLE_LIMIT  = 500000;

    // Keeps its own sorted store and queues the items the block must emit.
    class sort_scoreboard;
        logic [31:0]  store [CAPACITY];
        int unsigned  fill;
        bit           dropped;
        logic [2:0]   etype;
        isort_out_t   expected_q [$];
        int           errors;
        int           results_seen;
        int           runs_done;
        int           overflow_runs;

        function new();
            fill          = 0;
            dropped       = 0;
            etype         = ETYPE_RESET;
            errors        = 0;
            results_seen  = 0;
            runs_done     = 0;
            overflow_runs = 0;
        endfunction

        function logic [31:0] lane_mask(input logic [2:0] t);
            case (t)
                ETYPE_S8, ETYPE_U8:   return 32'h0000_00FF;
                ETYPE_S16, ETYPE_U16: return 32'h0000_FFFF;
                default:              return 32'hFFFF_FFFF;
            endcase
        endfunction

        function logic [31:0] sign_bit(input logic [2:0] t);
            case (t)
                ETYPE_S8:  return 32'h0000_0080;
                ETYPE_S16: return 32'h0000_8000;
                ETYPE_S32: return 32'h8000_0000;
                default:   return 32'h0;
            endcase
        endfunction

        function logic [31:0] order_key(input logic [31:0] v, input logic [2:0] t);
            return (v & lane_mask(t)) ^ sign_bit(t);
        endfunction

        function void report(input string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endfunction

        function void note_item(input logic [31:0] value, input logic last);
            logic [31:0] v;
            logic [31:0] m;
            int          pos;
            isort_out_t  r;
            m = lane_mask(etype);
            v = value & m;
            if (fill < CAPACITY)
            begin
                pos = fill;
                // Equal keys stay in arrival order; only larger entries move up.
                while (pos > 0 && order_key(store[pos-1], etype) > order_key(v, etype))
                begin
                    store[pos] = store[pos-1];
                    pos--;
                end
                store[pos] = v;
                fill++;
            end
            else
                dropped = 1;
            if (last)
            begin
                for (int k = 0; k < fill; k++)
                begin
                    r.value = store[k] & m;
                    r.last  = (k == fill - 1);
                    r.ovf   = dropped;
                    expected_q.push_back(r);
                end
                runs_done++;
                if (dropped)
                    overflow_runs++;
                fill    = 0;
                dropped = 0;
            end
        endfunction

        function void check_result(input logic [31:0] value, input logic last,
                                   input logic ovf);
            isort_out_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected item value=%h last=%b ovf=%b", value, last, ovf));
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value)
                report($sformatf("sorted value %h, expected %h", value, e.value));
            if (last !== e.last)
                report($sformatf("last flag %b, expected %b (value %h)", last, e.last, e.value));
            if (ovf !== e.ovf)
                report($sformatf("overflow flag %b, expected %b (value %h)", ovf, e.ovf, e.value));
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d expected items never arrived", expected_q.size()));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    sort_scoreboard sb;
    int          cycle_count;
    int          src_gap_pct;
    int          sink_stall_pct;
    int          random_items;
    bit [7:0]    types_seen;

    insertion_sort_engine_unit #(
        .MAX_ELEMENTS (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // Sink side: stall bursts at the rate chosen for the current phase.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [31:0] value, input logic last);
        if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(value, last);
    endtask

    // Holds the source off until every sorted item is out and the last
    // insertion has had time to finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 4) @(posedge clk);
    endtask

    task automatic set_type(input logic [2:0] t);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.etype = t;
        types_seen[t] = 1'b1;
    endtask

    // Mixes width extremes, sign boundaries, duplicates and junk above the width.
    function automatic logic [31:0] pick_value(input logic [2:0] t);
        logic [31:0] m;
        logic [31:0] top;
        logic [31:0] v;
        m   = sb.lane_mask(t);
        top = m ^ (m >> 1);
        case ($urandom_range(0, 9))
            0:       v = 32'h0;
            1:       v = m;
            2:       v = top;
            3:       v = top - 1;
            4, 5:    v = $urandom_range(0, 3);
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1))
            v = (v & m) | ($urandom & ~m);
        return v;
    endfunction

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_value(sb.etype), i == len - 1);
    endtask

    initial
    begin
        logic [2:0] type_order [8];
        logic [2:0] t;
        int         phase;
        int         len;

        sb             = new();
        cycle_count    = 0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = ETYPE_RESET;
        s_tvalid       = 1'b0;
        s_tdata        = 32'h0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        random_items   = 0;
        types_seen     = '0;
        type_order     = '{ETYPE_S8, ETYPE_U32, 3'd7, ETYPE_S16, 3'd6, ETYPE_S32,
                           ETYPE_U16, ETYPE_U8};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Type after reset is unsigned 8; junk above bit 7 must be ignored.
        send_item(32'h0000_00FF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h1234_5680, 1'b0);
        send_item(32'h0000_007F, 1'b1);

        set_type(ETYPE_S8);
        send_item(32'h0000_0080, 1'b0);
        send_item(32'h0000_007F, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h0000_0080, 1'b1);

        set_type(ETYPE_S16);
        send_item(32'h0000_8000, 1'b0);
        send_item(32'hFFFF_7FFF, 1'b0);
        send_item(32'h0000_0001, 1'b1);

        set_type(ETYPE_S32);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b1);

        set_type(ETYPE_U32);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b1);

        // A run of a single element.
        set_type(ETYPE_U16);
        send_item(32'hABCD_1234, 1'b1);

        // Undefined codes order as unsigned 32.
        set_type(3'd6);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        set_type(3'd7);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);

        // Type switched halfway through a run: earlier entries keep their
        // place and the output is masked with the type at the marked item.
        set_type(ETYPE_U8);
        send_item(32'h0000_0090, 1'b0);
        send_item(32'h0000_0010, 1'b0);
        set_type(ETYPE_S8);
        send_item(32'h0000_0020, 1'b0);
        send_item(32'h0000_0085, 1'b1);

        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= RANDOM_ITEMS * 4 / 5)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                src_gap_pct    = $urandom_range(5, 40);
                sink_stall_pct = $urandom_range(5, 40);
            end
            t = (phase < 8) ? type_order[phase] : 3'($urandom_range(0, 7));
            set_type(t);
            for (int r = $urandom_range(1, 4); r > 0; r--)
            begin
                // Full store exactly, then a dropped marked item, then one
                // unmarked drop before a dropped marked item.
                if (phase == 1 && r == 1)
                    len = CAPACITY;
                else if (phase == 3 && r == 1)
                    len = CAPACITY + 1;
                else if (phase == 5 && r == 1)
                    len = CAPACITY + 2;
                else if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(9, 20);
                else
                    len = $urandom_range(1, 8);
                send_run(len);
                random_items += len;
                if ($urandom_range(0, 3) == 0)
                    wait_idle();
            end
            phase++;
        end

        wait_idle();
        repeat (CAPACITY * 2) @(posedge clk);
        sb.close_out();
        $display("Sorted %0d runs (%0d with dropped elements), %0d items checked.",
                 sb.runs_done, sb.overflow_runs, sb.results_seen);
        $display("Element type codes written, one bit per code from 7 down to 0: %b",
                 types_seen);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/isort_pkg.sv
rtl/isort_ram.sv
rtl/isort_out.sv
rtl/isort_core.sv
rtl/insertion_sort_engine_unit.sv
tb/insertion_sort_engine_unit_tb.sv
